// ===== rtl/keyed_ordered_contact_list_defines.svh =====
// Assertion macros for the keyed ordered contact list.
// Included by the modules that carry concurrent checks; expects clk and arst_n in scope.
`ifndef KEYED_ORDERED_CONTACT_LIST_DEFINES_SVH
`define KEYED_ORDERED_CONTACT_LIST_DEFINES_SVH

// Property that must hold at every edge out of reset.
`define KOCL_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("kocl check failed");

// Antecedent in one cycle implies consequent in the next.
`define KOCL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kocl check failed");

`endif

// ===== rtl/kocl_pkg.sv =====
// Shared constants, command and status codes, and cell control type.
// No dependencies.
package kocl_pkg;

	localparam int CAPACITY_DEF  = 32;
	localparam int INFO_BITS_DEF = 48;
	localparam int KEY_BITS      = 256;
	localparam int WORD_BITS     = 64;
	localparam int CMD_W         = 3;
	localparam int STATUS_W      = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP_KEY  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_OLD  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_NEW  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic append;
		logic update;
		logic remove;
	} kc_ctl_t;

endpackage

// ===== rtl/kocl_cell.sv =====
// One slot of the contact list: stored key and payload, key compare, shift from neighbor.
// Depends on kocl_pkg.
module kocl_cell
	import kocl_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int INFO_BITS = INFO_BITS_DEF,
	parameter int IDX       = 0
) (
	input  logic                         clk,
	input  kc_ctl_t                      ctl,
	input  logic [$clog2(CAPACITY)-1:0]  pos,
	input  logic [$clog2(CAPACITY+1)-1:0] count,
	input  logic [KEY_BITS-1:0]          bkey,
	input  logic [INFO_BITS-1:0]         binfo,
	input  logic [KEY_BITS-1:0]          nxt_key,
	input  logic [INFO_BITS-1:0]         nxt_info,
	output logic [KEY_BITS-1:0]          key,
	output logic [INFO_BITS-1:0]         info,
	output logic                         match
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY+1);

	logic [KEY_BITS-1:0]  key_q;
	logic [INFO_BITS-1:0] info_q;
	logic                 match_s1;
	logic                 hit;

	always_comb begin
		hit = (count > CW'(IDX)) && (key_q == bkey);
	end

	always_ff @(posedge clk) begin
		match_s1 <= hit;
		if (ctl.remove && (pos <= IW'(IDX))) begin
			key_q  <= nxt_key;
			info_q <= nxt_info;
		end else if (ctl.append && (count == CW'(IDX))) begin
			key_q  <= bkey;
			info_q <= binfo;
		end else if (ctl.update && match_s1) begin
			info_q <= binfo;
		end
	end

	assign key   = key_q;
	assign info  = info_q;
	assign match = match_s1;

endmodule

// ===== rtl/keyed_ordered_contact_list.sv =====
// Top level of the keyed ordered contact list: command sequencer, cell row, result register.
// Depends on kocl_pkg, kocl_cell and keyed_ordered_contact_list_defines.svh.
//
// Insertion-ordered list of up to CAPACITY entries, each a 256-bit key and a payload.
// Commands arrive on the s_ channel, one transaction each: insert/update, pop by key,
// pop oldest, pop newest, contains. Every command yields exactly one result transaction
// on the m_ channel: status, removed entry (zero if none) and the entry count.
// Each slot is a cell holding one entry; all cells compare the key in parallel and,
// on removal, every cell at or above the removed slot loads its upper neighbor.
// Sequence: a command is registered on acceptance, the cells register the key compare in
// the compare state, and the result register loads in the update state. A new command is
// taken only in the idle state or in the cycle its predecessor commits.
// Reset empties the list (entry count to zero); slot contents are not cleared.
// A stalled result holds in the output register; a finished compare then waits
// in the update cycle and no further command is taken until the result drains.
`include "keyed_ordered_contact_list_defines.svh"
module keyed_ordered_contact_list
	import kocl_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int INFO_BITS = INFO_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// cmd, key_word0, key_word1, key_word2, key_word3, contact_info, zero fill
	input  logic [((CMD_W+KEY_BITS+INFO_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// status, out_word0, out_word1, out_word2, out_word3, out_info, entry_total, zero fill
	output logic [((STATUS_W+KEY_BITS+INFO_BITS+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_tdata
);

	localparam int IW    = $clog2(CAPACITY);
	localparam int CW    = $clog2(CAPACITY+1);
	localparam int OUT_B = STATUS_W + KEY_BITS + INFO_BITS + CW;
	localparam int OUT_W = ((OUT_B + 7) / 8) * 8;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;

	logic [1:0]           state_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [INFO_BITS-1:0] info_q;
	logic [CW-1:0]        count_q;

	logic                 m_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [KEY_BITS-1:0]  okey_q;
	logic [INFO_BITS-1:0] oinfo_q;
	logic [CW-1:0]        total_q;

	logic [KEY_BITS-1:0]  ckey  [CAPACITY];
	logic [INFO_BITS-1:0] cinfo [CAPACITY];
	logic [CAPACITY-1:0]  cmatch;

	kc_ctl_t              ctl;
	logic [IW-1:0]        pos;
	logic [IW-1:0]        enc;
	logic                 any_hit;
	logic                 commit;
	logic                 accept;
	logic [STATUS_W-1:0]  status_d;
	logic [CW-1:0]        count_d;
	logic [KEY_BITS-1:0]  okey_d;
	logic [INFO_BITS-1:0] oinfo_d;

	assign commit   = (state_q == S_UPD) && (!m_valid_q || m_tready);
	assign s_tready = (state_q == S_IDLE) || commit;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		enc = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cmatch[i]) begin
				enc = enc | IW'(i);
			end
		end
		any_hit = |cmatch;
	end

	always_comb begin
		ctl      = '0;
		pos      = '0;
		status_d = ST_NONE;
		count_d  = count_q;
		unique case (cmd_q)
			CMD_INSERT: begin
				if (any_hit) begin
					ctl.update = commit;
					status_d   = ST_OK;
				end else if (count_q != CW'(CAPACITY)) begin
					ctl.append = commit;
					status_d   = ST_OK;
					count_d    = count_q + CW'(1);
				end else begin
					status_d = ST_FULL;
				end
			end
			CMD_POP_KEY: begin
				if (any_hit) begin
					ctl.remove = commit;
					pos        = enc;
					status_d   = ST_OK;
					count_d    = count_q - CW'(1);
				end
			end
			CMD_POP_OLD: begin
				if (count_q != '0) begin
					ctl.remove = commit;
					status_d   = ST_OK;
					count_d    = count_q - CW'(1);
				end
			end
			CMD_POP_NEW: begin
				if (count_q != '0) begin
					ctl.remove = commit;
					pos        = IW'(count_q - CW'(1));
					status_d   = ST_OK;
					count_d    = count_q - CW'(1);
				end
			end
			CMD_CONTAINS: begin
				if (any_hit) begin
					status_d = ST_OK;
				end
			end
			default: begin
				status_d = ST_NONE;
			end
		endcase
	end

	// removed entry: one-hot select of the slot at pos
	always_comb begin
		okey_d  = '0;
		oinfo_d = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (ctl.remove && (pos == IW'(i))) begin
				okey_d  = okey_d | ckey[i];
				oinfo_d = oinfo_d | cinfo[i];
			end
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [KEY_BITS-1:0]  nkey;
		logic [INFO_BITS-1:0] ninfo;
		if (g == CAPACITY - 1) begin : g_last
			assign nkey  = '0;
			assign ninfo = '0;
		end else begin : g_mid
			assign nkey  = ckey[g+1];
			assign ninfo = cinfo[g+1];
		end
		kocl_cell #(
			.CAPACITY  (CAPACITY),
			.INFO_BITS (INFO_BITS),
			.IDX       (g)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.pos      (pos),
			.count    (count_q),
			.bkey     (key_q),
			.binfo    (info_q),
			.nxt_key  (nkey),
			.nxt_info (ninfo),
			.key      (ckey[g]),
			.info     (cinfo[g]),
			.match    (cmatch[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (commit) begin
						state_q <= accept ? S_CMP : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				count_q   <= count_d;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= s_tdata[CMD_W-1:0];
			key_q  <= s_tdata[CMD_W+KEY_BITS-1:CMD_W];
			info_q <= s_tdata[CMD_W+KEY_BITS+INFO_BITS-1:CMD_W+KEY_BITS];
		end
		if (commit) begin
			status_q <= status_d;
			okey_q   <= okey_d;
			oinfo_q  <= oinfo_d;
			total_q  <= count_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'({total_q, oinfo_q, okey_q, status_q});

	`KOCL_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(CAPACITY))
	`KOCL_ASSERT_ALWAYS(a_match_unique, (state_q != S_UPD) || $onehot0(cmatch))
	`KOCL_ASSERT_NEXT(a_append_grows, ctl.append, count_q == $past(count_q) + CW'(1))
	`KOCL_ASSERT_NEXT(a_remove_shrinks, ctl.remove, count_q == $past(count_q) - CW'(1))
	`KOCL_ASSERT_NEXT(a_accept_compares, accept, state_q == S_CMP)

endmodule
